FILE: hdl/dhpwm_pkg.sv
package dhpwm_pkg;

  localparam int PERIOD_W = 16;
  localparam int SPEED_W  = 7;
  localparam int DIR_W    = 3;
  localparam int PROD_W   = PERIOD_W + SPEED_W;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
  localparam logic [SPEED_W-1:0]  PERCENT_FULL = 7'd100;

  // floor(x / 100) = (x * DIV_RECIP) >> DIV_SHIFT, exact for x < 2^23
  localparam int               DIV_SHIFT = 30;
  localparam int               RECIP_W   = 24;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 24'd10737419;
  localparam int               MUL_W     = PROD_W + RECIP_W;

  localparam int QDEPTH   = 4;
  localparam int QCNT_W   = $clog2(QDEPTH + 1);
  localparam int OUT_DEPTH = 2;
  localparam int OCNT_W   = $clog2(OUT_DEPTH + 1);

  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic signed [DIR_W-1:0] DIR_FWD   = 3'sd1;
  localparam logic signed [DIR_W-1:0] DIR_REV   = -3'sd1;
  localparam logic signed [DIR_W-1:0] DIR_BRAKE = 3'sd0;

  localparam logic [1:0] PINS_FWD   = 2'b10;
  localparam logic [1:0] PINS_REV   = 2'b01;
  localparam logic [1:0] PINS_BRAKE = 2'b11;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DIR   = 2'd1,
    ST_BAD_SPEED = 2'd2,
    ST_BAD_MOTOR = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SEL_A   = 2'd0,
    SEL_B   = 2'd1,
    SEL_ALL = 2'd2,
    SEL_BAD = 2'd3
  } sel_t;

  typedef struct packed {
    logic                is_tick;
    status_t             status;
    sel_t                sel;
    logic [1:0]          pins;
    logic                drive;
    logic [PERIOD_W-1:0] high;
  } item_t;

  typedef struct packed {
    logic    a_in1;
    logic    a_in2;
    logic    b_in1;
    logic    b_in2;
    logic    a_enable;
    logic    b_enable;
    status_t status;
  } result_t;

endpackage

FILE: hdl/dhpwm_queue.sv
module dhpwm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < CNT_W'(DEPTH)) || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

FILE: hdl/dhpwm_front.sv
module dhpwm_front
  import dhpwm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       opcode,
  input  logic [1:0]                 motor_select,
  input  logic signed [DIR_W-1:0]    direction,
  input  logic [SPEED_W-1:0]         speed,
  input  logic                       speed_given,
  input  logic [PERIOD_W-1:0]        period,
  input  logic [QCNT_W-1:0]          q_count,
  output logic                       q_push,
  output item_t                      q_item
);

  logic                accept;
  logic [QCNT_W-1:0]   occupancy;
  logic [SPEED_W-1:0]  spd;
  logic [1:0]          pins;
  status_t             status;
  logic                drive;
  logic [PERIOD_W-1:0] eff_period;
  logic [PROD_W-1:0]   prod;

  logic                s1_valid;
  item_t               s1_item;
  logic [PROD_W-1:0]   s1_prod;
  logic                s2_valid;
  item_t               s2_item;
  logic [MUL_W-1:0]    quot_wide;
  item_t               s1_done;

  // items in flight count against the queue so nothing is dropped
  assign occupancy = q_count + QCNT_W'(s1_valid) + QCNT_W'(s2_valid);
  assign full      = occupancy >= QCNT_W'(QDEPTH);
  assign accept    = push && !full;

  always_comb begin
    spd    = speed_given ? speed : PERCENT_FULL;
    status = ST_OK;
    unique case (direction)
      DIR_FWD:   pins = PINS_FWD;
      DIR_REV:   pins = PINS_REV;
      DIR_BRAKE: pins = PINS_BRAKE;
      default: begin
        pins   = PINS_BRAKE;
        status = ST_BAD_DIR;
      end
    endcase
    if (status == ST_OK && spd > PERCENT_FULL) begin
      status = ST_BAD_SPEED;
    end
    if (status == ST_OK && motor_select == SEL_BAD) begin
      status = ST_BAD_MOTOR;
    end
    drive      = (direction != DIR_BRAKE) && (spd != '0);
    eff_period = (period == '0) ? PERIOD_W'(1) : period;
    prod       = PROD_W'(eff_period) * PROD_W'(spd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  // stage one: classify and form period*speed
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.is_tick <= (opcode == OP_TICK);
      s1_item.status  <= (opcode == OP_TICK) ? ST_OK : status;
      s1_item.sel     <= sel_t'(motor_select);
      s1_item.pins    <= pins;
      s1_item.drive   <= drive;
      s1_item.high    <= '0;
      s1_prod         <= prod;
    end
  end

  // stage two: divide by 100 through the reciprocal
  assign quot_wide = (MUL_W'(s1_prod) * MUL_W'(DIV_RECIP)) >> DIV_SHIFT;

  always_comb begin
    s1_done      = s1_item;
    s1_done.high = quot_wide[PERIOD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_item <= s1_done;
    end
  end

  assign q_push = s2_valid;
  assign q_item = s2_item;

endmodule

FILE: hdl/dhpwm_back.sv
module dhpwm_back
  import dhpwm_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  item_t               it,
  input  logic [PERIOD_W-1:0] period,
  output result_t             res
);

  localparam int CMP_W = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;

  logic [1:0]             dir_pins        [2];
  logic                   running         [2];
  logic                   phase_high      [2];
  logic [COUNT_WIDTH-1:0] left            [2];
  logic [COUNT_WIDTH-1:0] high_ticks      [2];
  logic [1:0]             dir_pins_next   [2];
  logic                   running_next    [2];
  logic                   phase_high_next [2];
  logic [COUNT_WIDTH-1:0] left_next       [2];
  logic [COUNT_WIDTH-1:0] high_ticks_next [2];

  logic [CMP_W-1:0]       per;
  logic [CMP_W-1:0]       quot;
  logic                   cmd_ok;

  always_comb begin
    logic [COUNT_WIDTH-1:0] dec;
    logic [CMP_W-1:0]       hi_ext;
    logic [CMP_W-1:0]       low_len;
    per    = CMP_W'((period == '0) ? PERIOD_W'(1) : period);
    quot   = CMP_W'(it.high);
    cmd_ok = go && !it.is_tick && (it.status == ST_OK);
    dec     = '0;
    hi_ext  = '0;
    low_len = '0;
    for (int c = 0; c < 2; c++) begin
      dir_pins_next[c]   = dir_pins[c];
      running_next[c]    = running[c];
      phase_high_next[c] = phase_high[c];
      left_next[c]       = left[c];
      high_ticks_next[c] = high_ticks[c];
      hi_ext  = CMP_W'(high_ticks[c]);
      low_len = per - hi_ext;
      dec     = (left[c] != '0) ? left[c] - COUNT_WIDTH'(1) : left[c];
      if (go && it.is_tick && running[c]) begin
        left_next[c] = dec;
        if (dec == '0) begin
          if (phase_high[c]) begin
            if (per > hi_ext) begin
              phase_high_next[c] = 1'b0;
              left_next[c]       = low_len[COUNT_WIDTH-1:0];
            end else begin
              // duty at or above the period: stay high for a whole period
              left_next[c] = per[COUNT_WIDTH-1:0];
            end
          end else if (high_ticks[c] != '0) begin
            phase_high_next[c] = 1'b1;
            left_next[c]       = high_ticks[c];
          end else begin
            left_next[c] = per[COUNT_WIDTH-1:0];
          end
        end
      end else if (cmd_ok && it.sel == SEL_ALL) begin
        dir_pins_next[c]   = PINS_BRAKE;
        running_next[c]    = 1'b0;
        phase_high_next[c] = 1'b0;
        left_next[c]       = '0;
      end else if (cmd_ok && it.sel == sel_t'(2'(c))) begin
        dir_pins_next[c] = it.pins;
        if (it.drive) begin
          high_ticks_next[c] = quot[COUNT_WIDTH-1:0];
          if (!running[c]) begin
            running_next[c]    = 1'b1;
            phase_high_next[c] = 1'b0;
            left_next[c]       = '0;
          end
        end else begin
          running_next[c]    = 1'b0;
          phase_high_next[c] = 1'b0;
          left_next[c]       = '0;
        end
      end
    end
  end

  always_comb begin
    res.a_in1    = dir_pins_next[0][1];
    res.a_in2    = dir_pins_next[0][0];
    res.b_in1    = dir_pins_next[1][1];
    res.b_in2    = dir_pins_next[1][0];
    res.a_enable = running_next[0] && phase_high_next[0];
    res.b_enable = running_next[1] && phase_high_next[1];
    res.status   = it.is_tick ? ST_OK : it.status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 2; c++) begin
        dir_pins[c]   <= '0;
        running[c]    <= 1'b0;
        phase_high[c] <= 1'b0;
        left[c]       <= '0;
        high_ticks[c] <= '0;
      end
    end else begin
      for (int c = 0; c < 2; c++) begin
        dir_pins[c]   <= dir_pins_next[c];
        running[c]    <= running_next[c];
        phase_high[c] <= phase_high_next[c];
        left[c]       <= left_next[c];
        high_ticks[c] <= high_ticks_next[c];
      end
    end
  end

  a_idle_chan_clear: assert property (@(posedge clk) disable iff (rst)
    !running[0] |-> (left[0] == '0) && !phase_high[0])
    else $error("stopped channel A holds phase state");

  a_reject_holds_pins: assert property (@(posedge clk) disable iff (rst)
    (go && !it.is_tick && it.status != ST_OK) |=>
      (dir_pins[0] == $past(dir_pins[0])) && (dir_pins[1] == $past(dir_pins[1])))
    else $error("rejected command changed direction pins");

  a_stop_all: assert property (@(posedge clk) disable iff (rst)
    (cmd_ok && it.sel == SEL_ALL) |=> !running[0] && !running[1])
    else $error("stop all left a channel running");

endmodule

FILE: hdl/dual_hbridge_pwm_controller.sv
// an item passes stage one, stage two, the command queue and the result queue
// throughput: one item per cycle, sustained while results are popped at the same rate
// front: classify plus two-stage period*speed/100, then a 4-entry queue to the back
// back: channel state update on each pop from the queue, into a 2-entry result queue
// reset (rst, synchronous): queues empty, channels stopped, channel pins low, period 1000
module dual_hbridge_pwm_controller
  import dhpwm_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [PERIOD_W-1:0]     cfg_data,
  input  logic                    push,
  output logic                    full,
  input  logic                    opcode,
  input  logic [1:0]              motor_select,
  input  logic signed [DIR_W-1:0] direction,
  input  logic [SPEED_W-1:0]      speed,
  input  logic                    speed_given,
  output logic                    empty,
  input  logic                    pop,
  output logic                    a_in1,
  output logic                    a_in2,
  output logic                    b_in1,
  output logic                    b_in2,
  output logic                    a_enable,
  output logic                    b_enable,
  output logic [1:0]              status
);

  logic [PERIOD_W-1:0] period;
  logic                q_push;
  item_t               q_in;
  item_t               q_out;
  logic [QCNT_W-1:0]   q_count;
  logic                back_go;
  result_t             res_in;
  result_t             res_out;
  logic [OCNT_W-1:0]   out_count;
  logic                out_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
    end else if (cfg_write) begin
      period <= cfg_data;
    end
  end

  dhpwm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .opcode       (opcode),
    .motor_select (motor_select),
    .direction    (direction),
    .speed        (speed),
    .speed_given  (speed_given),
    .period       (period),
    .q_count      (q_count),
    .q_push       (q_push),
    .q_item       (q_in)
  );

  dhpwm_queue #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QDEPTH)
  ) u_cmd_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (back_go),
    .pop_data  (q_out),
    .count     (q_count)
  );

  assign back_go = (q_count != '0) && (out_count < OCNT_W'(OUT_DEPTH));

  dhpwm_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .go     (back_go),
    .it     (q_out),
    .period (period),
    .res    (res_in)
  );

  dhpwm_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (back_go),
    .push_data (res_in),
    .pop       (out_pop),
    .pop_data  (res_out),
    .count     (out_count)
  );

  assign empty    = (out_count == '0);
  assign out_pop  = pop && !empty;
  assign a_in1    = res_out.a_in1;
  assign a_in2    = res_out.a_in2;
  assign b_in1    = res_out.b_in1;
  assign b_in2    = res_out.b_in2;
  assign a_enable = res_out.a_enable;
  assign b_enable = res_out.b_enable;
  assign status   = res_out.status;

endmodule
